[hw/rtl/rmsprop_momentum_weight_update_unit_macros.svh]
// ----------------------------------------------------------------------------
// RMSProp update unit assertion macros
// Shared concurrent assertion forms for the weight update unit.
// ----------------------------------------------------------------------------
`ifndef RMSPROP_MOMENTUM_WEIGHT_UPDATE_UNIT_MACROS_SVH
`define RMSPROP_MOMENTUM_WEIGHT_UPDATE_UNIT_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define RMWU_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> cons) \
      else $error("rmwu assertion failed");

// Consequent checked in the cycle after the antecedent.
`define RMWU_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> cons) \
      else $error("rmwu assertion failed");

`endif

[hw/rtl/rmwu_pkg.sv]
// ----------------------------------------------------------------------------
// RMSProp update unit package
// Widths, stage counts, register codes and transaction types.
// ----------------------------------------------------------------------------
package rmwu_pkg;

   localparam int unsigned VAL_W     = 48;
   localparam int unsigned RATE_W    = 40;
   localparam int unsigned DECAY_W   = 16;
   localparam int unsigned CSR_IDX_W = 2;
   localparam int unsigned PROD_W    = 87;
   localparam int unsigned ROOT_W    = 32;
   localparam int unsigned QUO_W     = 62;
   localparam int unsigned SQ_STAGES  = 16;
   localparam int unsigned DIV_STAGES = 31;
   localparam int unsigned LATENCY    = 55;

   localparam logic [RATE_W-1:0]  LR_RESET = 40'd10995116278;
   localparam logic [DECAY_W-1:0] SD_RESET = 16'd58982;
   localparam logic [DECAY_W-1:0] MD_RESET = 16'd58982;

   localparam logic signed [VAL_W-1:0] S48_MAX = 48'sh7FFF_FFFF_FFFF;
   localparam logic signed [VAL_W-1:0] S48_MIN = 48'sh8000_0000_0000;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LEARNING_RATE  = 2'd0,
      CSR_SQUARE_DECAY   = 2'd1,
      CSR_MOMENTUM_DECAY = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [RATE_W-1:0]  rate;
      logic [DECAY_W-1:0] square_decay;
      logic [DECAY_W-1:0] momentum_decay;
   } rmwu_cfg_type;

   typedef struct packed {
      logic signed [VAL_W-1:0] weight_in;
      logic signed [VAL_W-1:0] gradient_in;
      logic [VAL_W-1:0]        mean_square_in;
      logic signed [VAL_W-1:0] momentum_in;
   } rmwu_req_type;

   typedef struct packed {
      logic signed [VAL_W-1:0] weight_out;
      logic [VAL_W-1:0]        mean_square_out;
      logic signed [VAL_W-1:0] momentum_out;
      logic                    overflow;
   } rmwu_rsp_type;

   // Per-item values carried alongside the root and divide pipelines.
   typedef struct packed {
      logic signed [VAL_W-1:0] weight;
      logic                    grad_neg;
      logic signed [VAL_W-1:0] decayed;
      logic                    ms_ovf;
      logic [VAL_W-1:0]        mean_square;
   } rmwu_side_type;

endpackage

[hw/rtl/rmwu_front.sv]
// ----------------------------------------------------------------------------
// RMSProp update front end
// Five stages: magnitudes, partial products, product sums, decay product of
// the squared gradient, and the rounded, clamped new mean square.
// ----------------------------------------------------------------------------
module rmwu_front import rmwu_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  rmwu_cfg_type        cfg,
   input  logic                in_valid,
   input  rmwu_req_type        in_item,
   output logic                out_valid,
   output rmwu_side_type       out_side,
   output logic [PROD_W-1:0]   out_prod
);

   // Stage 1: signs and magnitudes.
   logic                    v1_ff;
   logic signed [VAL_W-1:0] w1_ff;
   logic                    gneg1_ff, mneg1_ff;
   logic [VAL_W-1:0]        gmag1_ff, mmag1_ff, ms1_ff;
   logic [VAL_W-1:0]        gmag1_in, mmag1_in;

   always_comb begin
      gmag1_in = in_item.gradient_in[VAL_W-1] ? 48'(-in_item.gradient_in) : in_item.gradient_in;
      mmag1_in = in_item.momentum_in[VAL_W-1] ? 48'(-in_item.momentum_in) : in_item.momentum_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
      end
      w1_ff    <= in_item.weight_in;
      gneg1_ff <= in_item.gradient_in[VAL_W-1];
      mneg1_ff <= in_item.momentum_in[VAL_W-1];
      gmag1_ff <= gmag1_in;
      mmag1_ff <= mmag1_in;
      ms1_ff   <= in_item.mean_square_in;
   end

   // Stage 2: partial products, each at most 24 by 24 bits.
   logic                    v2_ff;
   logic signed [VAL_W-1:0] w2_ff;
   logic                    gneg2_ff, mneg2_ff;
   logic [47:0] gg_ll_ff, gg_lh_ff, gg_hh_ff;
   logic [39:0] dm_l_ff, dm_h_ff, mm_l_ff, mm_h_ff;
   logic [43:0] pr_ll_ff, pr_lh_ff, pr_hl_ff, pr_hh_ff;
   logic [47:0] gg_ll_in, gg_lh_in, gg_hh_in;
   logic [39:0] dm_l_in, dm_h_in, mm_l_in, mm_h_in;
   logic [43:0] pr_ll_in, pr_lh_in, pr_hl_in, pr_hh_in;
   logic [23:0] gl, gh;
   logic [19:0] rl, rh;

   always_comb begin
      gl = gmag1_ff[23:0];
      gh = gmag1_ff[47:24];
      rl = cfg.rate[19:0];
      rh = cfg.rate[39:20];
      gg_ll_in = 48'(gl) * 48'(gl);
      gg_lh_in = 48'(gl) * 48'(gh);
      gg_hh_in = 48'(gh) * 48'(gh);
      dm_l_in  = 40'(cfg.square_decay) * 40'(ms1_ff[23:0]);
      dm_h_in  = 40'(cfg.square_decay) * 40'(ms1_ff[47:24]);
      mm_l_in  = 40'(cfg.momentum_decay) * 40'(mmag1_ff[23:0]);
      mm_h_in  = 40'(cfg.momentum_decay) * 40'(mmag1_ff[47:24]);
      pr_ll_in = 44'(rl) * 44'(gl);
      pr_lh_in = 44'(rl) * 44'(gh);
      pr_hl_in = 44'(rh) * 44'(gl);
      pr_hh_in = 44'(rh) * 44'(gh);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v1_ff;
      end
      w2_ff    <= w1_ff;
      gneg2_ff <= gneg1_ff;
      mneg2_ff <= mneg1_ff;
      gg_ll_ff <= gg_ll_in;
      gg_lh_ff <= gg_lh_in;
      gg_hh_ff <= gg_hh_in;
      dm_l_ff  <= dm_l_in;
      dm_h_ff  <= dm_h_in;
      mm_l_ff  <= mm_l_in;
      mm_h_ff  <= mm_h_in;
      pr_ll_ff <= pr_ll_in;
      pr_lh_ff <= pr_lh_in;
      pr_hl_ff <= pr_hl_in;
      pr_hh_ff <= pr_hh_in;
   end

   // Stage 3: sum the partial products; round the decayed momentum.
   logic                    v3_ff;
   logic signed [VAL_W-1:0] w3_ff, dec3_ff;
   logic                    gneg3_ff;
   logic [94:0]             g2_ff;
   logic [63:0]             dm3_ff;
   logic [PROD_W-1:0]       prod3_ff;
   logic [94:0]             g2_in;
   logic [63:0]             dm3_in, mm_sum;
   logic [PROD_W-1:0]       prod3_in;
   logic signed [VAL_W-1:0] dec3_in;

   always_comb begin
      g2_in    = 95'(gg_ll_ff) + (95'(gg_lh_ff) << 25) + (95'(gg_hh_ff) << 48);
      dm3_in   = 64'(dm_l_ff) + (64'(dm_h_ff) << 24);
      prod3_in = 87'(pr_ll_ff) + (87'(pr_lh_ff) << 24) + (87'(pr_hl_ff) << 20)
               + (87'(pr_hh_ff) << 44);
      mm_sum   = 64'(mm_l_ff) + (64'(mm_h_ff) << 24) + 64'd32768;
      dec3_in  = mneg2_ff ? 48'(-mm_sum[63:16]) : mm_sum[63:16];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else begin
         v3_ff <= v2_ff;
      end
      w3_ff    <= w2_ff;
      gneg3_ff <= gneg2_ff;
      dec3_ff  <= dec3_in;
      g2_ff    <= g2_in;
      dm3_ff   <= dm3_in;
      prod3_ff <= prod3_in;
   end

   // Stage 4: squared gradient times (1 - decay), in slices of 32, 32 and 31 bits.
   logic                    v4_ff;
   logic signed [VAL_W-1:0] w4_ff, dec4_ff;
   logic                    gneg4_ff;
   logic [63:0]             dm4_ff;
   logic [PROD_W-1:0]       prod4_ff;
   logic [48:0]             ep0_ff, ep1_ff, ep2_ff;
   logic [48:0]             ep0_in, ep1_in, ep2_in;
   logic [16:0]             one_minus_d;

   always_comb begin
      one_minus_d = 17'd65536 - 17'(cfg.square_decay);
      ep0_in = 49'(g2_ff[31:0]) * 49'(one_minus_d);
      ep1_in = 49'(g2_ff[63:32]) * 49'(one_minus_d);
      ep2_in = 49'(g2_ff[94:64]) * 49'(one_minus_d);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else begin
         v4_ff <= v3_ff;
      end
      w4_ff    <= w3_ff;
      gneg4_ff <= gneg3_ff;
      dec4_ff  <= dec3_ff;
      dm4_ff   <= dm3_ff;
      prod4_ff <= prod3_ff;
      ep0_ff   <= ep0_in;
      ep1_ff   <= ep1_in;
      ep2_ff   <= ep2_in;
   end

   // Stage 5: add, round half up, scale down and clamp the mean square.
   logic              v5_ff;
   rmwu_side_type     side5_ff;
   logic [PROD_W-1:0] prod5_ff;
   rmwu_side_type     side5_in;
   logic [111:0]      ms_sum;

   always_comb begin
      ms_sum = {8'd0, dm4_ff, 40'd0} + 112'(ep0_ff) + (112'(ep1_ff) << 32)
             + (112'(ep2_ff) << 64) + (112'd1 << 55);
      side5_in.weight      = w4_ff;
      side5_in.grad_neg    = gneg4_ff;
      side5_in.decayed     = dec4_ff;
      side5_in.ms_ovf      = |ms_sum[111:104];
      side5_in.mean_square = side5_in.ms_ovf ? '1 : ms_sum[103:56];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
      end else begin
         v5_ff <= v4_ff;
      end
      side5_ff <= side5_in;
      prod5_ff <= prod4_ff;
   end

   assign out_valid = v5_ff;
   assign out_side  = side5_ff;
   assign out_prod  = prod5_ff;

endmodule

[hw/rtl/rmwu_sqrt.sv]
// ----------------------------------------------------------------------------
// RMSProp update square root pipeline
// Digit-by-digit integer root of (mean square + 1) * 2^14, two root bits
// per stage, so the full root of each item is ready at the last stage.
// ----------------------------------------------------------------------------
module rmwu_sqrt import rmwu_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  rmwu_side_type       in_side,
   input  logic [PROD_W-1:0]   in_prod,
   output logic                out_valid,
   output rmwu_side_type       out_side,
   output logic [PROD_W-1:0]   out_prod,
   output logic [ROOT_W-1:0]   out_root
);

   typedef struct packed {
      logic [33:0]       rem;
      logic [ROOT_W-1:0] root;
   } sq_acc_type;

   // One root bit: bring down a bit pair and try (4 * root + 1).
   function automatic sq_acc_type sq_step(input sq_acc_type cur, input logic [1:0] pair);
      logic [35:0] rem_sh;
      logic [35:0] trial;
      sq_acc_type  nxt;
      rem_sh = {cur.rem, pair};
      trial  = {2'b00, cur.root, 2'b01};
      if (rem_sh >= trial) begin
         nxt.rem  = 34'(rem_sh - trial);
         nxt.root = {cur.root[ROOT_W-2:0], 1'b1};
      end else begin
         nxt.rem  = rem_sh[33:0];
         nxt.root = {cur.root[ROOT_W-2:0], 1'b0};
      end
      return nxt;
   endfunction

   logic              v_ff    [SQ_STAGES];
   rmwu_side_type     side_ff [SQ_STAGES];
   logic [PROD_W-1:0] prod_ff [SQ_STAGES];
   logic [63:0]       rad_ff  [SQ_STAGES];
   sq_acc_type        acc_ff  [SQ_STAGES];

   for (genvar k = 0; k < SQ_STAGES; k++) begin : g_stage
      logic              v_prev;
      rmwu_side_type     side_prev;
      logic [PROD_W-1:0] prod_prev;
      logic [63:0]       rad_prev;
      sq_acc_type        acc_prev, acc_mid, acc_in;

      if (k == 0) begin : g_first
         assign v_prev    = in_valid;
         assign side_prev = in_side;
         assign prod_prev = in_prod;
         assign rad_prev  = {1'b0, ({1'b0, in_side.mean_square} + 49'd1), 14'd0};
         assign acc_prev  = '0;
      end else begin : g_next
         assign v_prev    = v_ff[k-1];
         assign side_prev = side_ff[k-1];
         assign prod_prev = prod_ff[k-1];
         assign rad_prev  = rad_ff[k-1];
         assign acc_prev  = acc_ff[k-1];
      end

      // Two bit pairs of the radicand per stage, most significant first.
      assign acc_mid = sq_step(acc_prev, rad_prev[63-4*k -: 2]);
      assign acc_in  = sq_step(acc_mid, rad_prev[61-4*k -: 2]);

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else begin
            v_ff[k] <= v_prev;
         end
         side_ff[k] <= side_prev;
         prod_ff[k] <= prod_prev;
         rad_ff[k]  <= rad_prev;
         acc_ff[k]  <= acc_in;
      end
   end

   assign out_valid = v_ff[SQ_STAGES-1];
   assign out_side  = side_ff[SQ_STAGES-1];
   assign out_prod  = prod_ff[SQ_STAGES-1];
   assign out_root  = acc_ff[SQ_STAGES-1].root;

endmodule

[hw/rtl/rmwu_div.sv]
// ----------------------------------------------------------------------------
// RMSProp update divide pipeline
// Rounds the rate-gradient product against the root, then a restoring
// divide that yields two quotient bits per stage over DIV_STAGES stages.
// ----------------------------------------------------------------------------
module rmwu_div import rmwu_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  rmwu_side_type       in_side,
   input  logic [PROD_W-1:0]   in_prod,
   input  logic [ROOT_W-1:0]   in_root,
   output logic                out_valid,
   output rmwu_side_type       out_side,
   output logic [QUO_W-1:0]    out_quo,
   output logic                out_big
);

   typedef struct packed {
      logic [ROOT_W-1:0] rem;
      logic [QUO_W-1:0]  quo;
   } dv_acc_type;

   // One quotient bit: shift in a dividend bit and subtract when it fits.
   function automatic dv_acc_type dv_step(input dv_acc_type cur, input logic nbit,
                                          input logic [ROOT_W-1:0] dvs);
      logic [ROOT_W:0] trial;
      dv_acc_type      nxt;
      trial = {cur.rem, nbit};
      if (trial >= {1'b0, dvs}) begin
         nxt.rem = ROOT_W'(trial - {1'b0, dvs});
         nxt.quo = {cur.quo[QUO_W-2:0], 1'b1};
      end else begin
         nxt.rem = trial[ROOT_W-1:0];
         nxt.quo = {cur.quo[QUO_W-2:0], 1'b0};
      end
      return nxt;
   endfunction

   // Prep stage: add half the divisor (root * 2^12) and drop 13 bits, so that
   // dividing by the root rounds half up against root * 2^13.
   logic              pv_ff;
   rmwu_side_type     pside_ff;
   logic [74:0]       pnum_ff;
   logic [ROOT_W-1:0] pdvs_ff;
   logic [87:0]       num_sum;

   always_comb begin
      num_sum = {1'b0, in_prod} + {44'd0, in_root, 12'd0};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pv_ff <= 1'b0;
      end else begin
         pv_ff <= in_valid;
      end
      pside_ff <= in_side;
      pnum_ff  <= num_sum[87:13];
      pdvs_ff  <= in_root;
   end

   logic              v_ff    [DIV_STAGES];
   rmwu_side_type     side_ff [DIV_STAGES];
   logic [QUO_W-1:0]  num_ff  [DIV_STAGES];
   logic [ROOT_W-1:0] dvs_ff  [DIV_STAGES];
   logic              big_ff  [DIV_STAGES];
   dv_acc_type        acc_ff  [DIV_STAGES];

   for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
      logic              v_prev, big_prev;
      rmwu_side_type     side_prev;
      logic [QUO_W-1:0]  num_prev;
      logic [ROOT_W-1:0] dvs_prev;
      dv_acc_type        acc_prev, acc_mid, acc_in;

      if (k == 0) begin : g_first
         // A quotient of 2^61 or more is clamped anyway; flag it here.
         assign v_prev    = pv_ff;
         assign side_prev = pside_ff;
         assign num_prev  = pnum_ff[QUO_W-1:0];
         assign dvs_prev  = pdvs_ff;
         assign big_prev  = ({18'd0, pnum_ff[74:61]} >= pdvs_ff);
         assign acc_prev  = {{19'd0, pnum_ff[74:62]}, {QUO_W{1'b0}}};
      end else begin : g_next
         assign v_prev    = v_ff[k-1];
         assign side_prev = side_ff[k-1];
         assign num_prev  = num_ff[k-1];
         assign dvs_prev  = dvs_ff[k-1];
         assign big_prev  = big_ff[k-1];
         assign acc_prev  = acc_ff[k-1];
      end

      assign acc_mid = dv_step(acc_prev, num_prev[QUO_W-1-2*k], dvs_prev);
      assign acc_in  = dv_step(acc_mid, num_prev[QUO_W-2-2*k], dvs_prev);

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else begin
            v_ff[k] <= v_prev;
         end
         side_ff[k] <= side_prev;
         num_ff[k]  <= num_prev;
         dvs_ff[k]  <= dvs_prev;
         big_ff[k]  <= big_prev;
         acc_ff[k]  <= acc_in;
      end
   end

   assign out_valid = v_ff[DIV_STAGES-1];
   assign out_side  = side_ff[DIV_STAGES-1];
   assign out_quo   = acc_ff[DIV_STAGES-1].quo;
   assign out_big   = big_ff[DIV_STAGES-1];

endmodule

[hw/rtl/rmsprop_momentum_weight_update_unit.sv]
// A result strobes once its transaction has passed the front, root, divide, momentum and weight stages.
// Throughput: one transaction per cycle; busy is low whenever reset is low.
// The depth is set by the 16-stage root pipeline and 32-stage divide pipeline.
// Reset (synchronous) empties the pipeline and restores the register defaults.
// ----------------------------------------------------------------------------
// RMSProp with momentum weight update unit
// Updates mean square, momentum and weight of one Q8.40 weight per
// transaction, saturating each result and flagging any saturation.
// ----------------------------------------------------------------------------
`include "rmsprop_momentum_weight_update_unit_macros.svh"

module rmsprop_momentum_weight_update_unit import rmwu_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  rmwu_req_type         req_data,
   output logic                 rsp_valid,
   output rmwu_rsp_type         rsp_data,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [RATE_W-1:0]    csr_wdata
);

   // Configuration registers.
   rmwu_cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.rate           <= LR_RESET;
         cfg_ff.square_decay   <= SD_RESET;
         cfg_ff.momentum_decay <= MD_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_LEARNING_RATE:  cfg_ff.rate           <= csr_wdata;
            CSR_SQUARE_DECAY:   cfg_ff.square_decay   <= csr_wdata[DECAY_W-1:0];
            CSR_MOMENTUM_DECAY: cfg_ff.momentum_decay <= csr_wdata[DECAY_W-1:0];
            default: ;
         endcase
      end
   end

   // The pipeline never stalls; it only refuses transactions during reset.
   logic accept;
   assign busy   = reset;
   assign accept = start && !busy;

   logic              fr_valid, sq_valid, div_valid, div_big;
   rmwu_side_type     fr_side, sq_side, div_side;
   logic [PROD_W-1:0] fr_prod, sq_prod;
   logic [ROOT_W-1:0] sq_root;
   logic [QUO_W-1:0]  div_quo;

   rmwu_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (accept),
      .in_item   (req_data),
      .out_valid (fr_valid),
      .out_side  (fr_side),
      .out_prod  (fr_prod)
   );

   rmwu_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fr_valid),
      .in_side   (fr_side),
      .in_prod   (fr_prod),
      .out_valid (sq_valid),
      .out_side  (sq_side),
      .out_prod  (sq_prod),
      .out_root  (sq_root)
   );

   rmwu_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sq_valid),
      .in_side   (sq_side),
      .in_prod   (sq_prod),
      .in_root   (sq_root),
      .out_valid (div_valid),
      .out_side  (div_side),
      .out_quo   (div_quo),
      .out_big   (div_big)
   );

   // Momentum stage: clamp the step, apply it against the gradient sign.
   logic                    mom_valid_ff, mom_ovf_ff;
   logic signed [VAL_W-1:0] mom_ff;
   rmwu_side_type           mom_side_ff;
   logic [60:0]             step;
   logic signed [63:0]      mom_wide;
   logic                    mom_ovf_in;
   logic signed [VAL_W-1:0] mom_in;

   always_comb begin
      if (div_big || (div_quo > (62'd1 << 60))) begin
         step = 61'd1 << 60;
      end else begin
         step = div_quo[60:0];
      end
      if (div_side.grad_neg) begin
         mom_wide = 64'(div_side.decayed) + $signed({3'd0, step});
      end else begin
         mom_wide = 64'(div_side.decayed) - $signed({3'd0, step});
      end
      mom_ovf_in = (mom_wide[63:VAL_W-1] != {(64-VAL_W+1){mom_wide[VAL_W-1]}});
      if (mom_ovf_in) begin
         mom_in = mom_wide[63] ? S48_MIN : S48_MAX;
      end else begin
         mom_in = mom_wide[VAL_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mom_valid_ff <= 1'b0;
      end else begin
         mom_valid_ff <= div_valid;
      end
      mom_ovf_ff  <= mom_ovf_in;
      mom_ff      <= mom_in;
      mom_side_ff <= div_side;
   end

   // Weight stage: add the saturated momentum and form the result.
   logic         rsp_valid_ff;
   rmwu_rsp_type rsp_data_ff;
   rmwu_rsp_type rsp_data_in;
   logic [VAL_W:0] w_sum;
   logic         w_ovf;

   always_comb begin
      w_sum = {mom_side_ff.weight[VAL_W-1], mom_side_ff.weight} + {mom_ff[VAL_W-1], mom_ff};
      w_ovf = (w_sum[VAL_W] != w_sum[VAL_W-1]);
      if (w_ovf) begin
         rsp_data_in.weight_out = w_sum[VAL_W] ? S48_MIN : S48_MAX;
      end else begin
         rsp_data_in.weight_out = w_sum[VAL_W-1:0];
      end
      rsp_data_in.mean_square_out = mom_side_ff.mean_square;
      rsp_data_in.momentum_out    = mom_ff;
      rsp_data_in.overflow        = mom_side_ff.ms_ovf || mom_ovf_ff || w_ovf;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= mom_valid_ff;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Every accepted transaction strobes its result after the full depth.
   `RMWU_ASSERT_NOW(a_latency, clock, reset, accept, ##LATENCY rsp_valid)
   // A quotient flagged too large must saturate the momentum.
   `RMWU_ASSERT_NEXT(a_big_saturates, clock, reset, div_valid && div_big, mom_ovf_ff)
   // Reset leaves no result strobe behind.
   `RMWU_ASSERT_NEXT(a_reset_clears, clock, 1'b0, reset, !rsp_valid)

endmodule

[sim/tb_rmsprop_momentum_weight_update_unit.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// RMSProp update unit testbench
// Drives weight update transactions through the unit under several register
// settings, predicts each result in the bench and compares every field.
// ----------------------------------------------------------------------------
module tb_rmsprop_momentum_weight_update_unit;
   import rmwu_pkg::*;

   localparam logic [127:0] MASK48     = 128'hFFFF_FFFF_FFFF;
   localparam logic [127:0] STEP_LIMIT = 128'd1 << 60;
   localparam longint       MAX48      = 64'sd140737488355327;
   localparam longint       MIN48      = -64'sd140737488355328;
   localparam int           IDLE_LIMIT = 3000;
   localparam int           RAND_ITEMS = 1630;

   typedef struct {
      rmwu_req_type req;
      bit           fixed;
      rmwu_rsp_type rsp;
   } stim_row_type;

   logic                 clock;
   logic                 reset;
   logic                 start;
   logic                 busy;
   rmwu_req_type         req_data;
   logic                 rsp_valid;
   rmwu_rsp_type         rsp_data;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [RATE_W-1:0]    csr_wdata;

   // Register copy used by the predictor.
   logic [RATE_W-1:0]    cur_rate;
   logic [DECAY_W-1:0]   cur_sq_decay;
   logic [DECAY_W-1:0]   cur_mo_decay;

   rmwu_rsp_type         pending_updates[$];
   int                   error_count;
   int                   idle_cycles;

   rmsprop_momentum_weight_update_unit u_top (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      clock = 1'b1;
      #1;
      clock = 1'b0;
      #1;
   end

   // Integer square root, bit by bit.
   function automatic logic [63:0] int_sqrt64(input logic [63:0] x);
      logic [63:0] res;
      logic [63:0] bitv;
      res  = 0;
      bitv = 64'd1 << 62;
      while (bitv > x) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (x >= res + bitv) begin
            x   = x - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   function automatic longint clamp48(input longint v, inout bit ovf);
      if (v > MAX48) begin
         ovf = 1'b1;
         return MAX48;
      end
      if (v < MIN48) begin
         ovf = 1'b1;
         return MIN48;
      end
      return v;
   endfunction

   // Expected weight update for one transaction under the current registers.
   function automatic rmwu_rsp_type calc_weight_update(input rmwu_req_type r);
      longint       w, g, m, dec, mn, wn;
      logic [127:0] gmag, mmag, acc, msn, root, den, num, quo, dmag;
      bit           ovf;
      rmwu_rsp_type o;
      ovf  = 1'b0;
      w    = longint'($signed(r.weight_in));
      g    = longint'($signed(r.gradient_in));
      m    = longint'($signed(r.momentum_in));
      gmag = (g < 0) ? 128'(-g) : 128'(g);
      mmag = (m < 0) ? 128'(-m) : 128'(m);

      // New mean square, rounded half up and clamped.
      acc = ((128'(cur_sq_decay) * 128'(r.mean_square_in)) << 40)
            + (128'(65536 - int'(cur_sq_decay)) * gmag * gmag) + (128'd1 << 55);
      msn = acc >> 56;
      if (msn > MASK48) begin
         msn = MASK48;
         ovf = 1'b1;
      end

      // Step magnitude from the root of mean square plus one lsb.
      root = 128'(int_sqrt64(64'((msn + 1) << 14)));
      den  = root << 13;
      num  = 128'(cur_rate) * gmag + (den >> 1);
      quo  = num / den;
      if (quo > STEP_LIMIT) quo = STEP_LIMIT;

      // Decayed momentum, half away from zero.
      dmag = (128'(cur_mo_decay) * mmag + 128'd32768) >> 16;
      dec  = (m < 0) ? -longint'(dmag) : longint'(dmag);
      mn   = (g < 0) ? dec + longint'(quo) : dec - longint'(quo);
      mn   = clamp48(mn, ovf);
      wn   = clamp48(w + mn, ovf);

      o.weight_out      = wn[47:0];
      o.mean_square_out = msn[47:0];
      o.momentum_out    = mn[47:0];
      o.overflow        = ovf;
      return o;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      error_count++;
   endtask

   // Result monitor: each strobe is checked against the oldest expectation.
   always @(posedge clock) begin
      rmwu_rsp_type exp_rsp;
      if (!reset && rsp_valid) begin
         if (pending_updates.size() == 0) begin
            report_mismatch("result with no transaction outstanding");
         end else begin
            exp_rsp = pending_updates.pop_front();
            if (rsp_data.weight_out !== exp_rsp.weight_out)
               report_mismatch($sformatf("weight_out %h expected %h",
                  rsp_data.weight_out, exp_rsp.weight_out));
            if (rsp_data.mean_square_out !== exp_rsp.mean_square_out)
               report_mismatch($sformatf("mean_square_out %h expected %h",
                  rsp_data.mean_square_out, exp_rsp.mean_square_out));
            if (rsp_data.momentum_out !== exp_rsp.momentum_out)
               report_mismatch($sformatf("momentum_out %h expected %h",
                  rsp_data.momentum_out, exp_rsp.momentum_out));
            if (rsp_data.overflow !== exp_rsp.overflow)
               report_mismatch($sformatf("overflow %b expected %b",
                  rsp_data.overflow, exp_rsp.overflow));
         end
      end
   end

   // Watchdog on cycles in which no transaction and no result moves.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   // Send one transaction; start stays high on return for back-to-back use.
   task automatic send_update(input rmwu_req_type r, input bit fixed,
                              input rmwu_rsp_type fixed_rsp);
      rmwu_rsp_type pred;
      start    = 1'b1;
      req_data = r;
      forever begin
         @(posedge clock);
         if (!busy) break;
      end
      pred = calc_weight_update(r);
      if (fixed && pred !== fixed_rsp)
         report_mismatch("predictor disagrees with a hand-computed row");
      pending_updates.push_back(fixed ? fixed_rsp : pred);
      @(negedge clock);
   endtask

   task automatic idle_gap();
      int n;
      case ($urandom_range(0, 19))
         0:       n = $urandom_range(20, 90);
         1, 2, 3: n = $urandom_range(1, 4);
         default: n = 0;
      endcase
      if (n > 0) begin
         start = 1'b0;
         repeat (n) @(negedge clock);
      end
   endtask

   // Register write, issued only once every result is back.
   task automatic write_csr(input csr_index_type idx, input logic [RATE_W-1:0] val);
      start = 1'b0;
      while (pending_updates.size() != 0) @(negedge clock);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      @(negedge clock);
      csr_we = 1'b0;
      case (idx)
         CSR_LEARNING_RATE:  cur_rate     = val;
         CSR_SQUARE_DECAY:   cur_sq_decay = val[DECAY_W-1:0];
         CSR_MOMENTUM_DECAY: cur_mo_decay = val[DECAY_W-1:0];
         default: ;
      endcase
   endtask

   function automatic logic [47:0] rand_field(input bit is_unsigned);
      logic [63:0] raw;
      raw = {$urandom, $urandom};
      case ($urandom_range(0, 11))
         0:       return 48'h0;
         1:       return is_unsigned ? 48'hFFFF_FFFF_FFFF : 48'h7FFF_FFFF_FFFF;
         2:       return is_unsigned ? 48'h1 : 48'h8000_0000_0000;
         3, 4:    return raw[47:0];
         5, 6:    return is_unsigned ? {12'h0, raw[35:0]} : {{12{raw[36]}}, raw[35:0]};
         default: return is_unsigned ? {18'h0, raw[29:0]} : {{18{raw[30]}}, raw[29:0]};
      endcase
   endfunction

   function automatic logic [RATE_W-1:0] rand_setting(input int width);
      logic [63:0] raw;
      logic [63:0] mask;
      raw  = {$urandom, $urandom};
      mask = (64'd1 << width) - 64'd1;
      case ($urandom_range(0, 3))
         0:       return '0;
         1:       return mask[RATE_W-1:0];
         default: return raw[RATE_W-1:0] & mask[RATE_W-1:0];
      endcase
   endfunction

   initial begin
      stim_row_type rows[$];
      stim_row_type row;
      rmwu_req_type r;
      rmwu_rsp_type none;

      start        = 1'b0;
      req_data     = '0;
      csr_we       = 1'b0;
      csr_index    = '0;
      csr_wdata    = '0;
      reset        = 1'b1;
      error_count  = 0;
      idle_cycles  = 0;
      none         = '0;
      cur_rate     = LR_RESET;
      cur_sq_decay = SD_RESET;
      cur_mo_decay = MD_RESET;

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed table; all-zero and zero-gradient rows are worked by hand.
      row.fixed = 1'b1;
      row.req   = '0;
      row.rsp   = '0;
      rows.push_back(row);
      row.req.weight_in  = S48_MAX;
      row.rsp.weight_out = S48_MAX;
      rows.push_back(row);
      row.req.weight_in  = S48_MIN;
      row.rsp.weight_out = S48_MIN;
      rows.push_back(row);
      row.fixed = 1'b0;
      row.rsp   = '0;
      // Huge gradients drive mean square saturation; extreme momenta decay.
      row.req = '{48'sh0, S48_MIN, 48'h0, 48'sh0};                      rows.push_back(row);
      row.req = '{48'sh0, S48_MAX, 48'h0, 48'sh0};                      rows.push_back(row);
      row.req = '{S48_MAX, -48'sd1, 48'h0, S48_MAX};                   rows.push_back(row);
      row.req = '{S48_MIN, 48'sd1, 48'h0, S48_MIN};                    rows.push_back(row);
      row.req = '{48'sh0, 48'sh0, 48'hFFFF_FFFF_FFFF, S48_MIN};         rows.push_back(row);
      row.req = '{48'sh0, 48'sh0, 48'hFFFF_FFFF_FFFF, S48_MAX};         rows.push_back(row);
      row.req = '{48'sh100, 48'sh10_0000_0000, 48'h100_0000_0000, -48'sd7}; rows.push_back(row);
      row.req = '{48'sh100, -48'sh10_0000_0000, 48'h1, 48'sd3};          rows.push_back(row);
      row.req = '{48'sh7FFF_FFFF_FF00, -48'sh1_0000_0000, 48'h0, 48'sh0}; rows.push_back(row);
      row.req = '{S48_MIN, S48_MAX, 48'hFFFF_FFFF_FFFF, S48_MIN};         rows.push_back(row);
      foreach (rows[i]) send_update(rows[i].req, rows[i].fixed, rows[i].rsp);

      // Extreme settings, first the largest rate with no mean-square decay.
      write_csr(CSR_LEARNING_RATE, 40'hFF_FFFF_FFFF);
      write_csr(CSR_SQUARE_DECAY, 40'h0);
      write_csr(CSR_MOMENTUM_DECAY, 40'hFFFF);
      foreach (rows[i]) send_update(rows[i].req, 1'b0, none);
      write_csr(CSR_LEARNING_RATE, 40'h0);
      write_csr(CSR_SQUARE_DECAY, 40'hFFFF);
      write_csr(CSR_MOMENTUM_DECAY, 40'h0);
      foreach (rows[i]) send_update(rows[i].req, 1'b0, none);

      // Random phases, each under fresh register settings.
      for (int k = 0; k < RAND_ITEMS; k++) begin
         if (k % 400 == 0) begin
            write_csr(CSR_LEARNING_RATE, rand_setting(RATE_W));
            write_csr(CSR_SQUARE_DECAY, rand_setting(DECAY_W));
            write_csr(CSR_MOMENTUM_DECAY, rand_setting(DECAY_W));
         end
         r.weight_in      = rand_field(1'b0);
         r.gradient_in    = rand_field(1'b0);
         r.mean_square_in = rand_field(1'b1);
         r.momentum_in    = rand_field(1'b0);
         idle_gap();
         send_update(r, 1'b0, none);
      end
      start = 1'b0;

      // Drain, then allow for the pipeline depth.
      while (pending_updates.size() != 0) @(negedge clock);
      repeat (LATENCY + 5) @(negedge clock);
      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

[files.f]
+incdir+hw/rtl
hw/rtl/rmwu_pkg.sv
hw/rtl/rmwu_front.sv
hw/rtl/rmwu_sqrt.sv
hw/rtl/rmwu_div.sv
hw/rtl/rmsprop_momentum_weight_update_unit.sv
sim/tb_rmsprop_momentum_weight_update_unit.sv
